[hdl/nmb_pkg.sv]
// shared types and character constants for the nroff markup blanker
`timescale 1ns / 1ps
`default_nettype none

package nmb_pkg;

	// characters the parser reacts to
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_QUOTE  = 8'h27;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_VT     = 8'h0B;
	localparam logic [7:0] CH_FF     = 8'h0C;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_F      = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_S      = 8'h73;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_LPAREN = 8'h28;
	localparam logic [7:0] CH_LBRACK = 8'h5B;
	localparam logic [7:0] CH_RBRACK = 8'h5D;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_PLUS   = 8'h2B;
	localparam logic [7:0] CH_MINUS  = 8'h2D;

	// two-letter request names, first letter in the upper byte
	localparam logic [15:0] REQ_DS = 16'h6473;
	localparam logic [15:0] REQ_DE = 16'h6465;
	localparam logic [15:0] REQ_NR = 16'h6E72;
	localparam logic [15:0] REQ_DO = 16'h646F;
	localparam logic [15:0] REQ_SO = 16'h736F;
	localparam logic [15:0] REQ_IF = 16'h6966;

	// parser states, one-hot
	typedef enum logic [13:0] {
		ST_INITIAL       = 14'b00000000000001,
		ST_ESCAPE        = 14'b00000000000010,
		ST_REQUEST       = 14'b00000000000100,
		ST_FONT          = 14'b00000000001000,
		ST_SIZE          = 14'b00000000010000,
		ST_SKIP_CHAR     = 14'b00000000100000,
		ST_SKIP_DIGIT    = 14'b00000001000000,
		ST_SKIP_SPACE_ID = 14'b00000010000000,
		ST_SKIP_IDENT    = 14'b00000100000000,
		ST_SKIP_COND     = 14'b00001000000000,
		ST_LEADING_WS    = 14'b00010000000000,
		ST_ARGUMENT      = 14'b00100000000000,
		ST_REGISTER      = 14'b01000000000000,
		ST_LONG_NAME     = 14'b10000000000000
	} pstate_t;

	// parser control state carried from item to item
	typedef struct packed {
		pstate_t    pstate;
		logic       at_line_start;
		logic [1:0] skip_count;
		logic       name_pos;
		logic       in_cond;
	} nmb_state_t;

endpackage

`default_nettype wire

[hdl/nroff_markup_blanker.sv]
// Streaming nroff markup blanker: each text byte comes out unchanged or, when it
// belongs to escapes, requests or their arguments, as a space; newlines always
// pass. One result item per input item, in order. An item is taken into an input
// register, judged by compare logic against the parser state, and the result
// lands in an output register; the parser state updates as the item moves on.
// Throughput is one item per clock while the output is not stalled; a result is
// shown once its item has passed the input register and the result register.
// While a result waits to be taken, the input register can still take one more
// item, and after that the input side stalls until the result leaves.
`timescale 1ns / 1ps
`default_nettype none

module nroff_markup_blanker (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       s_axis_tvalid,
	output logic            s_axis_tready,
	input  wire logic [7:0] s_axis_tdata,  // [7:0] in_char
	output logic            m_axis_tvalid,
	input  wire logic       m_axis_tready,
	output logic [7:0]      m_axis_tdata,  // [7:0] out_char
	output logic [0:0]      m_axis_tuser   // [0] blanked
);

	logic                valid_s1;
	logic [7:0]          char_s1;
	logic                valid_s2;
	logic [7:0]          char_s2;
	logic                blanked_s2;
	logic                adv_s1;
	logic                adv_s2;
	nmb_pkg::nmb_state_t state_q;
	nmb_pkg::nmb_state_t state_nxt;
	logic [7:0]          name0_q;
	logic [7:0]          name0_nxt;
	logic                mark;

	// flow control
	assign adv_s2        = !valid_s2 || m_axis_tready;
	assign adv_s1        = valid_s1 && adv_s2;
	assign s_axis_tready = !valid_s1 || adv_s2;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) char_s1 <= s_axis_tdata;
	end

	// markup decision
	nmb_step u_step (
		.c         (char_s1),
		.cur       (state_q),
		.name0     (name0_q),
		.nxt       (state_nxt),
		.nxt_name0 (name0_nxt),
		.mark      (mark)
	);

	// parser state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q.pstate        <= nmb_pkg::ST_INITIAL;
			state_q.at_line_start <= 1'b1;
			state_q.skip_count    <= 2'd0;
			state_q.name_pos      <= 1'b0;
			state_q.in_cond       <= 1'b0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// first letter of the request name
	always_ff @(posedge clk) begin
		if (adv_s1) name0_q <= name0_nxt;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			char_s2    <= (mark && char_s1 != nmb_pkg::CH_LF) ? nmb_pkg::CH_SPACE : char_s1;
			blanked_s2 <= mark;
		end
	end

	assign m_axis_tvalid   = valid_s2;
	assign m_axis_tdata    = char_s2;
	assign m_axis_tuser[0] = blanked_s2;

endmodule

`default_nettype wire

[hdl/nmb_step.sv]
// next-state and markup decision for one text byte
`timescale 1ns / 1ps
`default_nettype none

module nmb_step (
	input  wire logic [7:0]         c,
	input  wire nmb_pkg::nmb_state_t cur,
	input  wire logic [7:0]         name0,
	output nmb_pkg::nmb_state_t     nxt,
	output logic [7:0]              nxt_name0,
	output logic                    mark
);

	typedef struct packed {
		logic             hit;
		nmb_pkg::pstate_t pstate;
		logic             clr_pos;
	} init_res_t;

	// dispatch from the initial state
	function automatic init_res_t initial_dispatch(
		input logic [7:0] ch,
		input logic       ls,
		input logic       cond
	);
		init_res_t r;
		r.hit     = 1'b0;
		r.pstate  = nmb_pkg::ST_INITIAL;
		r.clr_pos = 1'b0;
		if (ch == nmb_pkg::CH_BSLASH) begin
			r.hit    = 1'b1;
			r.pstate = nmb_pkg::ST_ESCAPE;
		end else if (ch == nmb_pkg::CH_DOT || ch == nmb_pkg::CH_QUOTE) begin
			if (ls) begin
				r.hit    = 1'b1;
				r.pstate = nmb_pkg::ST_LEADING_WS;
			end else if (cond) begin
				r.hit     = 1'b1;
				r.pstate  = nmb_pkg::ST_REQUEST;
				r.clr_pos = 1'b1;
			end
		end
		return r;
	endfunction

	logic             ws;
	logic             digit;
	logic             pos_eff;
	logic [15:0]      pair;
	logic             skip_arg;
	nmb_pkg::pstate_t req_pstate;
	logic             req_pos;
	logic             req_write;
	init_res_t        init_cur;
	init_res_t        init_cond;

	// character classes
	always_comb begin
		ws    = c inside {nmb_pkg::CH_SPACE, nmb_pkg::CH_TAB, nmb_pkg::CH_LF,
		                  nmb_pkg::CH_VT, nmb_pkg::CH_FF, nmb_pkg::CH_CR};
		digit = c inside {[nmb_pkg::CH_ZERO:nmb_pkg::CH_NINE]};
	end

	// request name collection
	always_comb begin
		pos_eff  = (cur.pstate == nmb_pkg::ST_LEADING_WS) ? 1'b0 : cur.name_pos;
		pair     = {name0, c};
		skip_arg = pair inside {nmb_pkg::REQ_DS, nmb_pkg::REQ_DE, nmb_pkg::REQ_NR,
		                        nmb_pkg::REQ_DO, nmb_pkg::REQ_SO};
		req_write = 1'b0;
		req_pos   = pos_eff;
		if (c == nmb_pkg::CH_LF || c == nmb_pkg::CH_DOT) begin
			req_pstate = nmb_pkg::ST_INITIAL;
		end else if (!pos_eff) begin
			req_pstate = nmb_pkg::ST_REQUEST;
			req_write  = 1'b1;
			req_pos    = 1'b1;
		end else begin
			req_pos = 1'b0;
			if (skip_arg) begin
				req_pstate = nmb_pkg::ST_SKIP_SPACE_ID;
			end else if (pair == nmb_pkg::REQ_IF) begin
				req_pstate = nmb_pkg::ST_SKIP_COND;
			end else begin
				req_pstate = nmb_pkg::ST_SKIP_IDENT;
			end
		end
	end

	// initial-state dispatch, plain and with the conditional mode forced on
	always_comb begin
		init_cur  = initial_dispatch(c, cur.at_line_start, cur.in_cond);
		init_cond = initial_dispatch(c, cur.at_line_start, 1'b1);
	end

	// parser step
	always_comb begin
		nxt       = cur;
		nxt_name0 = name0;
		mark      = 1'b0;
		if (cur.skip_count != 2'd0) begin
			nxt.skip_count = cur.skip_count - 2'd1;
			mark           = 1'b1;
		end else begin
			case (cur.pstate)
				nmb_pkg::ST_INITIAL: begin
					mark       = init_cur.hit;
					nxt.pstate = init_cur.pstate;
					if (init_cur.clr_pos) nxt.name_pos = 1'b0;
				end
				nmb_pkg::ST_ESCAPE: begin
					mark       = 1'b1;
					nxt.pstate = nmb_pkg::ST_INITIAL;
					case (c)
						nmb_pkg::CH_F:      nxt.pstate = nmb_pkg::ST_FONT;
						nmb_pkg::CH_STAR,
						nmb_pkg::CH_N:      nxt.pstate = nmb_pkg::ST_REGISTER;
						nmb_pkg::CH_S:      nxt.pstate = nmb_pkg::ST_SIZE;
						nmb_pkg::CH_LPAREN: nxt.skip_count = 2'd2;
						nmb_pkg::CH_LBRACK: nxt.pstate = nmb_pkg::ST_LONG_NAME;
						nmb_pkg::CH_DQUOTE: nxt.pstate = nmb_pkg::ST_INITIAL;
						nmb_pkg::CH_BSLASH: nxt.pstate = nmb_pkg::ST_ESCAPE;
						nmb_pkg::CH_DOLLAR: nxt.pstate = nmb_pkg::ST_ARGUMENT;
						default:            mark = 1'b0;
					endcase
				end
				nmb_pkg::ST_REGISTER: begin
					nxt.pstate = nmb_pkg::ST_INITIAL;
					if (c == nmb_pkg::CH_LPAREN) begin
						nxt.skip_count = 2'd2;
						mark           = 1'b1;
					end else if (c == nmb_pkg::CH_LBRACK) begin
						nxt.pstate = nmb_pkg::ST_LONG_NAME;
						mark       = 1'b1;
					end
				end
				nmb_pkg::ST_LONG_NAME: begin
					mark = 1'b1;
					if (c == nmb_pkg::CH_RBRACK || c == nmb_pkg::CH_LF)
						nxt.pstate = nmb_pkg::ST_INITIAL;
				end
				nmb_pkg::ST_FONT: begin
					mark       = 1'b1;
					nxt.pstate = nmb_pkg::ST_INITIAL;
					if (c == nmb_pkg::CH_LPAREN) nxt.skip_count = 2'd2;
				end
				nmb_pkg::ST_SIZE: begin
					mark = 1'b1;
					if (c == nmb_pkg::CH_PLUS || c == nmb_pkg::CH_MINUS)
						nxt.pstate = nmb_pkg::ST_SKIP_CHAR;
					else
						nxt.pstate = nmb_pkg::ST_SKIP_DIGIT;
				end
				nmb_pkg::ST_SKIP_CHAR: begin
					mark       = 1'b1;
					nxt.pstate = nmb_pkg::ST_SKIP_DIGIT;
				end
				nmb_pkg::ST_SKIP_DIGIT: begin
					mark       = digit;
					nxt.pstate = nmb_pkg::ST_INITIAL;
				end
				nmb_pkg::ST_LEADING_WS: begin
					if (!ws) begin
						mark         = 1'b1;
						nxt.pstate   = req_pstate;
						nxt.name_pos = req_pos;
						if (req_write) nxt_name0 = c;
					end
				end
				nmb_pkg::ST_REQUEST: begin
					mark         = 1'b1;
					nxt.pstate   = req_pstate;
					nxt.name_pos = req_pos;
					if (req_write) nxt_name0 = c;
				end
				nmb_pkg::ST_SKIP_COND: begin
					if (ws) begin
						mark = 1'b1;
					end else begin
						nxt.in_cond = 1'b1;
						if (c == nmb_pkg::CH_T || c == nmb_pkg::CH_N) begin
							mark       = 1'b1;
							nxt.pstate = nmb_pkg::ST_INITIAL;
						end else begin
							// condition over: handle the byte again from the start
							mark       = init_cond.hit;
							nxt.pstate = init_cond.pstate;
							if (init_cond.clr_pos) nxt.name_pos = 1'b0;
						end
					end
				end
				nmb_pkg::ST_SKIP_SPACE_ID: begin
					mark = 1'b1;
					if (!ws) nxt.pstate = nmb_pkg::ST_SKIP_IDENT;
				end
				nmb_pkg::ST_SKIP_IDENT: begin
					mark = 1'b1;
					if (ws) begin
						nxt.pstate  = nmb_pkg::ST_INITIAL;
						nxt.in_cond = 1'b1;
					end
				end
				nmb_pkg::ST_ARGUMENT: begin
					if (digit) begin
						mark = 1'b1;
					end else begin
						// argument digits over: handle the byte again from the start
						mark       = init_cur.hit;
						nxt.pstate = init_cur.pstate;
						if (init_cur.clr_pos) nxt.name_pos = 1'b0;
					end
				end
				default: begin
					nxt.pstate = nmb_pkg::ST_INITIAL;
				end
			endcase
		end

		// line end bookkeeping
		nxt.at_line_start = (c == nmb_pkg::CH_LF);
		if (c == nmb_pkg::CH_LF) nxt.in_cond = 1'b0;
	end

endmodule

`default_nettype wire

[hdl/nmb_checker.sv]
// port-level checks for the nroff markup blanker, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module nmb_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       s_axis_tvalid,
	input wire logic       s_axis_tready,
	input wire logic [7:0] s_axis_tdata,
	input wire logic       m_axis_tvalid,
	input wire logic       m_axis_tready,
	input wire logic [7:0] m_axis_tdata,
	input wire logic [0:0] m_axis_tuser
);

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("result changed while stalled");

	// a blanked item shows a space, or a newline that always passes
	a_blank_value: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[0] |->
			(m_axis_tdata == nmb_pkg::CH_SPACE || m_axis_tdata == nmb_pkg::CH_LF))
		else $error("blanked item carries a visible byte");

	// with the output register empty the input side is never held off
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!m_axis_tvalid |-> s_axis_tready)
		else $error("input stalled with empty output register");

	// a newline accepted while the output register is empty shows up after the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready && !m_axis_tvalid && s_axis_tdata == nmb_pkg::CH_LF
			|=> ##1 m_axis_tvalid)
		else $error("item did not reach the output");

endmodule

bind nroff_markup_blanker nmb_checker u_nmb_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tvalid (s_axis_tvalid),
	.s_axis_tready (s_axis_tready),
	.s_axis_tdata  (s_axis_tdata),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
